// ===== rtl/core/fqs_pkg.sv =====
// Shared types and constants for the FIFO queue with content search.
// Operation and status codes, controller states, command and status bundles.
// No dependencies.
`default_nettype none
package fqs_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_SEARCH   = 2'd3
  } fqs_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4
  } fqs_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_TRAV,
    S_SRCH
  } fqs_state_t;

  typedef struct packed {
    logic        cap;
    logic        wr;
    logic        push;
    logic        pop;
    logic        rd_start;
    logic        rd_next;
    logic        emit;
    fqs_status_t emit_status;
    logic        emit_data;
    logic        emit_last;
  } fqs_cmd_t;

  typedef struct packed {
    fqs_op_t op;
    logic    full;
    logic    empty;
    logic    walk_last;
    logic    match;
    logic    out_free;
  } fqs_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/fifo_queue_with_search_core.sv =====
// FIFO queue with content search, top level.
// Throughput: one item at a time; traverse gives one beat per cycle while the output
// is not stalled, and search walks one entry per cycle, limited by the read port.
// Reset (rst_n, synchronous): queue empty, head at zero; entry memory is not cleared.
`default_nettype none
module fifo_queue_with_search_core
  import fqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               in_operation,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data,
  output logic                          out_last
);

  fqs_cmd_t cmd;
  fqs_sts_t sts;

  fqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fqs_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_value     (in_value),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/fqs_ctrl.sv =====
// Controller for the search queue: sequences insert, pop, traverse and search.
// Depends on fqs_pkg; drives commands to fqs_dp.
`default_nettype none
module fqs_ctrl
  import fqs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire fqs_sts_t sts,
  output fqs_cmd_t      cmd
);

  fqs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (sts.op == OP_INSERT || sts.empty) begin
          if (sts.out_free) state_nxt = S_IDLE;
        end else begin
          unique case (sts.op)
            OP_DELETE:   state_nxt = S_POP;
            OP_TRAVERSE: state_nxt = S_TRAV;
            OP_SEARCH:   state_nxt = S_SRCH;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_TRAV: begin
        if (sts.out_free && sts.walk_last) state_nxt = S_IDLE;
      end
      S_SRCH: begin
        if ((sts.match || sts.walk_last) && sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_status = ST_OK;
    in_stall     = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.cap = in_valid;
      end
      S_DISPATCH: begin
        if (sts.op == OP_INSERT) begin
          cmd.emit      = sts.out_free;
          cmd.emit_last = 1'b1;
          if (sts.full) begin
            cmd.emit_status = ST_FULL;
          end else begin
            cmd.wr   = sts.out_free;
            cmd.push = sts.out_free;
          end
        end else if (sts.empty) begin
          cmd.emit        = sts.out_free;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_EMPTY;
        end else begin
          cmd.rd_start = 1'b1;
        end
      end
      S_POP: begin
        cmd.emit      = sts.out_free;
        cmd.emit_data = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.pop       = sts.out_free;
      end
      S_TRAV: begin
        cmd.emit      = sts.out_free;
        cmd.emit_data = 1'b1;
        cmd.emit_last = sts.walk_last;
        cmd.rd_next   = sts.out_free && !sts.walk_last;
      end
      S_SRCH: begin
        cmd.emit_last = 1'b1;
        if (sts.match) begin
          cmd.emit        = sts.out_free;
          cmd.emit_status = ST_FOUND;
        end else if (sts.walk_last) begin
          cmd.emit        = sts.out_free;
          cmd.emit_status = ST_NOTFOUND;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("beat emitted while output register busy");
  a_cap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> state_r == S_DISPATCH)
    else $error("captured item not dispatched");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push into full ring");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !sts.empty)
    else $error("pop from empty ring");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/fqs_dp.sv =====
// Datapath for the search queue: entry memory, head/occupancy, walk pointer,
// compare and output register. Depends on fqs_pkg; driven by fqs_ctrl.
`default_nettype none
module fqs_dp
  import fqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [1:0]               in_operation,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire fqs_cmd_t                 cmd,
  output fqs_sts_t                      sts,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_status,
  output logic signed [DATA_W-1:0]      out_data,
  output logic                          out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  fqs_op_t            op_r;
  logic [DATA_W-1:0]  val_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic [SW-1:0]      tail_sum;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      ptr_inc;
  logic               out_valid_r;
  fqs_status_t        out_status_r;
  logic [DATA_W-1:0]  out_data_r;
  logic               out_last_r;

  always_comb begin
    tail_sum = SW'(head_r) + SW'(occ_r);
    if (tail_sum >= SW'(DEPTH)) tail_sum = tail_sum - SW'(DEPTH);
    tail = tail_sum[AW-1:0];
    ptr_inc = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  end

  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    if (cmd.pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      occ_nxt  = occ_r - CW'(1);
    end else if (cmd.push) begin
      occ_nxt = occ_r + CW'(1);
    end
    ptr_nxt = ptr_r;
    cnt_nxt = cnt_r;
    if (cmd.rd_start) begin
      ptr_nxt = head_r;
      cnt_nxt = '0;
    end else if (cmd.rd_next) begin
      ptr_nxt = ptr_inc;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    cnt_r <= cnt_nxt;
    if (cmd.cap) begin
      op_r  <= fqs_op_t'(in_operation);
      val_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[tail] <= val_r;
    if (cmd.rd_start || cmd.rd_next) rd_data_r <= mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_data_r   <= cmd.emit_data ? rd_data_r : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.full      = (occ_r == CW'(DEPTH));
    sts.empty     = (occ_r == '0);
    sts.walk_last = ((cnt_r + CW'(1)) == occ_r);
    sts.match     = (rd_data_r == val_r);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_last   = out_last_r;

`ifndef ASSERT_OFF
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_next |-> cnt_r + CW'(1) < occ_r)
    else $error("walk beyond stored entries");
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head index out of range");
`endif

endmodule
`default_nettype wire

// ===== dv/fifo_queue_with_search_core_tb.sv =====
// Self-checking testbench for fifo_queue_with_search_core: directed and random
// insert/delete/traverse/search traffic against a behavioral queue predictor.
// Depends on fqs_pkg and the core RTL.
`default_nettype none
module fifo_queue_with_search_core_tb
  import fqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Q_DEPTH      = DEPTH_DEF;
  localparam int SETTLE_CYC   = Q_DEPTH + 8;
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_CYC     = 150;

  typedef struct {
    fqs_status_t status;
    logic [31:0] data;
    logic        last;
  } q_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               in_operation;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [2:0]               out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;

  logic [31:0] queue_mem [Q_DEPTH];
  int unsigned queue_head;
  int unsigned queue_count;
  q_result_t   pending_results[$];
  q_result_t   want;
  int          errors;
  int          stuck_cycles;
  bit          idle_on;
  int          hold_left;
  int          stall_left;

  fifo_queue_with_search_core #(.DEPTH(Q_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_data(out_data), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_result(fqs_status_t st, logic [31:0] d, logic l);
    q_result_t r;
    r.status = st;
    r.data   = d;
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_queue_op(fqs_op_t op, logic [31:0] val);
    bit hit;
    hit = 1'b0;
    if (op == OP_INSERT) begin
      if (queue_count == Q_DEPTH) begin
        add_result(ST_FULL, '0, 1'b1);
      end else begin
        queue_mem[(queue_head + queue_count) % Q_DEPTH] = val;
        queue_count++;
        add_result(ST_OK, '0, 1'b1);
      end
    end else if (queue_count == 0) begin
      add_result(ST_EMPTY, '0, 1'b1);
    end else if (op == OP_DELETE) begin
      add_result(ST_OK, queue_mem[queue_head], 1'b1);
      queue_head = (queue_head + 1) % Q_DEPTH;
      queue_count--;
    end else if (op == OP_TRAVERSE) begin
      for (int i = 0; i < queue_count; i++)
        add_result(ST_OK, queue_mem[(queue_head + i) % Q_DEPTH], i + 1 == queue_count);
    end else begin
      for (int i = 0; i < queue_count; i++)
        if (queue_mem[(queue_head + i) % Q_DEPTH] == val) hit = 1'b1;
      add_result(hit ? ST_FOUND : ST_NOTFOUND, '0, 1'b1);
    end
  endfunction

  // valid stays high between back-to-back beats; it only drops for an idle gap
  task automatic send_item(input fqs_op_t op, input logic [31:0] val);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_queue_op(op, val);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // receiver: long hold-off when requested, else random stall bursts while idle_on is set
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat status=%0d data=%0h last=%0b",
                 $time, out_status, out_data, out_last);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want.status, out_status);
          errors++;
        end
        if (out_data !== want.data) begin
          $display("%0t: data mismatch expected %0h actual %0h",
                   $time, want.data, out_data);
          errors++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch expected %0b actual %0b",
                   $time, want.last, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic test_empty_queue();
    send_item(OP_DELETE, 32'h0);
    send_item(OP_TRAVERSE, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'h8000_0000);
  endtask

  task automatic test_extreme_values();
    send_item(OP_INSERT, 32'h7fff_ffff);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'h0);
    send_item(OP_INSERT, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'hffff_ffff);
    send_item(OP_SEARCH, 32'h1);
    send_item(OP_TRAVERSE, 32'h0);
    send_item(OP_DELETE, 32'h5555_5555);
  endtask

  task automatic test_full_queue();
    while (queue_count < Q_DEPTH) send_item(OP_INSERT, $urandom);
    send_item(OP_INSERT, 32'haaaa_aaaa);
    send_item(OP_TRAVERSE, 32'h0);
  endtask

  task automatic test_random_traffic(input int n_items, input bit with_idle);
    int          insert_pct;
    int          r;
    fqs_op_t     op;
    logic [31:0] val;
    idle_on    = with_idle;
    insert_pct = 25;
    for (int k = 0; k < n_items; k++) begin
      if (k % 32 == 0) insert_pct = (insert_pct == 25) ? 75 : 25;
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        op = OP_INSERT;
      end else begin
        r = $urandom_range(0, 9);
        op = (r < 5) ? OP_DELETE : (r < 7) ? OP_TRAVERSE : OP_SEARCH;
      end
      val = pick_value();
      if (op == OP_SEARCH && queue_count > 0 && $urandom_range(0, 1) == 1)
        val = queue_mem[(queue_head + $urandom_range(0, queue_count - 1)) % Q_DEPTH];
      send_item(op, val);
    end
  endtask

  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = HOLD_CYC;
    for (int k = 0; k < 24; k++)
      send_item((k % 3 == 2) ? OP_TRAVERSE : OP_INSERT, $urandom);
    wait_for_drain();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_value     = '0;
    out_stall    = 1'b0;
    idle_on      = 1'b0;
    hold_left    = 0;
    errors       = 0;
    stuck_cycles = 0;
    queue_head   = 0;
    queue_count  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_on = 1'b1;
    test_empty_queue();
    test_extreme_values();
    test_full_queue();
    test_random_traffic(130, 1'b1);
    test_backpressure();
    test_random_traffic(30, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_for_drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/fqs_pkg.sv
rtl/core/fqs_ctrl.sv
rtl/core/fqs_dp.sv
rtl/core/fifo_queue_with_search_core.sv
dv/fifo_queue_with_search_core_tb.sv
